FILE: hdl/rcs_pkg.sv
// Shared types and constants of the RGB contrast stretch block.
package rcs_pkg;

    localparam int PIX_W = 8;

    typedef logic [PIX_W-1:0] pix_t;

    // Action codes carried by an input word.
    localparam logic ACT_GATHER  = 1'b0;
    localparam logic ACT_STRETCH = 1'b1;

    // Reset values of the per-channel bounds.
    localparam pix_t LOW_RESET  = '1;
    localparam pix_t HIGH_RESET = '0;

    // Per-channel minimum and maximum.
    typedef struct packed {
        pix_t low;
        pix_t high;
    } bounds_t;

    // Sequencer commands to the channel lanes.
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

endpackage

FILE: hdl/rcs_if.sv
// Input and output word channels of the RGB contrast stretch block.
interface rcs_pix_in_if;
    logic          valid;
    logic          ready;
    logic          action;
    logic          first_of_frame;
    rcs_pkg::pix_t red_in;
    rcs_pkg::pix_t green_in;
    rcs_pkg::pix_t blue_in;

    modport source (output valid, action, first_of_frame, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, first_of_frame, red_in, green_in, blue_in,
                    output ready);
endinterface

interface rcs_pix_out_if;
    logic          valid;
    logic          ready;
    rcs_pkg::pix_t red_out;
    rcs_pkg::pix_t green_out;
    rcs_pkg::pix_t blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: hdl/rcs_stats.sv
// Running minimum and maximum of one color channel.
module rcs_stats (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            upd,
    input  logic            first,
    input  rcs_pkg::pix_t   value,
    output rcs_pkg::bounds_t bounds
);
    import rcs_pkg::*;

    pix_t low_reg, low_next;
    pix_t high_reg, high_next;

    // A first word restarts the bounds; otherwise they only widen.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (upd)
        begin
            if (first)
            begin
                low_next  = value;
                high_next = value;
            end
            else
            begin
                if (value < low_reg)
                begin
                    low_next = value;
                end
                if (value > high_reg)
                begin
                    high_next = value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign bounds.low  = low_reg;
    assign bounds.high = high_reg;

endmodule

FILE: hdl/rcs_lane.sv
// One channel lane: scale by the channel maximum, then a bit-serial restoring divide.
module rcs_lane #(
    parameter int CHANNEL_MAX = 255
) (
    input  logic              clk,
    input  rcs_pkg::lane_ctl_t ctl,
    input  rcs_pkg::pix_t     value,
    input  rcs_pkg::bounds_t  bounds,
    output rcs_pkg::pix_t     result
);
    import rcs_pkg::*;

    // The quotient stays below CHANNEL_MAX whenever the divide is used.
    localparam int QW = $clog2(CHANNEL_MAX + 1);
    localparam int NW = PIX_W + QW;

    logic          zero_reg, zero_next;
    logic          sat_reg, sat_next;
    pix_t          den_reg, den_next;
    pix_t          rem_reg, rem_next;
    logic [QW-1:0] work_reg, work_next;

    pix_t          diff;
    logic [NW-1:0] num;
    logic [PIX_W:0] shifted;
    logic          ge;

    // Setup: flags for the special cases and the scaled numerator.
    assign diff = value - bounds.low;
    assign num  = NW'(diff) * NW'(CHANNEL_MAX);

    // One restoring divide step: shift in a numerator bit, subtract if it fits.
    assign shifted = {rem_reg, work_reg[QW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        zero_next = zero_reg;
        sat_next  = sat_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        if (ctl.load)
        begin
            zero_next = (bounds.high <= bounds.low) || (value <= bounds.low);
            sat_next  = (value >= bounds.high);
            den_next  = bounds.high - bounds.low;
            rem_next  = num[NW-1:QW];
            work_next = num[QW-1:0];
        end
        else if (ctl.step)
        begin
            rem_next  = ge ? PIX_W'(shifted - {1'b0, den_reg}) : shifted[PIX_W-1:0];
            work_next = QW'({work_reg, ge});
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    // Flat or below-minimum channels give zero; at or above the maximum, full scale.
    always_comb
    begin
        if (zero_reg)
        begin
            result = '0;
        end
        else if (sat_reg)
        begin
            result = PIX_W'(CHANNEL_MAX);
        end
        else
        begin
            result = PIX_W'(work_reg);
        end
    end

endmodule

FILE: hdl/rgb_contrast_stretch.sv
// Top level of the per-channel RGB contrast stretch block.
// A gather word (action 0) widens the stored red, green and blue minima and
// maxima in the cycle it is accepted, and a word flagged first_of_frame
// restarts them from its own values; it gives no output word. A stretch word
// (action 1) maps each channel to (value - min) * CHANNEL_MAX / (max - min),
// truncated and clamped, and gives one output word. A channel whose max does
// not exceed its min, or whose value does not exceed the min, outputs 0. A
// stretch word passes from acceptance through a setup state, the bit-serial
// restoring divider in each lane, one quotient bit per cycle, and a write
// state into the output register, and the block takes no new word meanwhile.
// A finished word waits in the output register, and the block takes new
// input words while it waits.
module rgb_contrast_stretch #(
    parameter int CHANNEL_MAX = 255
) (
    input  logic          clk,
    input  logic          rst_n,
    rcs_pix_in_if.sink    pix_in,
    rcs_pix_out_if.source pix_out
);
    import rcs_pkg::*;

    localparam int QW = $clog2(CHANNEL_MAX + 1);
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    pix_t          red_reg, green_reg, blue_reg;
    pix_t          red_out_reg, green_out_reg, blue_out_reg;

    logic      in_acc;
    logic      gather_upd;
    logic      stretch_go;
    logic      out_load;
    lane_ctl_t lane_ctl;
    bounds_t   red_bounds, green_bounds, blue_bounds;
    pix_t      red_res, green_res, blue_res;

    assign pix_in.ready = (state_reg == ST_IDLE);
    assign in_acc       = pix_in.valid && pix_in.ready;
    assign gather_upd   = in_acc && (pix_in.action == ACT_GATHER);
    assign stretch_go   = in_acc && (pix_in.action == ACT_STRETCH);
    assign out_load     = (state_reg == ST_WRITE) && (!out_valid_reg || pix_out.ready);

    assign lane_ctl.load = (state_reg == ST_PREP);
    assign lane_ctl.step = (state_reg == ST_DIV);

    // Channel statistics.
    rcs_stats u_red_stats (
        .clk(clk), .rst_n(rst_n), .upd(gather_upd), .first(pix_in.first_of_frame),
        .value(pix_in.red_in), .bounds(red_bounds)
    );
    rcs_stats u_green_stats (
        .clk(clk), .rst_n(rst_n), .upd(gather_upd), .first(pix_in.first_of_frame),
        .value(pix_in.green_in), .bounds(green_bounds)
    );
    rcs_stats u_blue_stats (
        .clk(clk), .rst_n(rst_n), .upd(gather_upd), .first(pix_in.first_of_frame),
        .value(pix_in.blue_in), .bounds(blue_bounds)
    );

    // Channel lanes, stepped together by the sequencer.
    rcs_lane #(.CHANNEL_MAX(CHANNEL_MAX)) u_red_lane (
        .clk(clk), .ctl(lane_ctl), .value(red_reg), .bounds(red_bounds),
        .result(red_res)
    );
    rcs_lane #(.CHANNEL_MAX(CHANNEL_MAX)) u_green_lane (
        .clk(clk), .ctl(lane_ctl), .value(green_reg), .bounds(green_bounds),
        .result(green_res)
    );
    rcs_lane #(.CHANNEL_MAX(CHANNEL_MAX)) u_blue_lane (
        .clk(clk), .ctl(lane_ctl), .value(blue_reg), .bounds(blue_bounds),
        .result(blue_res)
    );

    // Sequencer: setup, one divide step per quotient bit, then hand off to the output register.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stretch_go)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = CW'(QW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pixel capture and output payload.
    always_ff @(posedge clk)
    begin
        if (stretch_go)
        begin
            red_reg   <= pix_in.red_in;
            green_reg <= pix_in.green_in;
            blue_reg  <= pix_in.blue_in;
        end
        if (out_load)
        begin
            red_out_reg   <= red_res;
            green_out_reg <= green_res;
            blue_out_reg  <= blue_res;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = red_out_reg;
    assign pix_out.green_out = green_out_reg;
    assign pix_out.blue_out  = blue_out_reg;

endmodule

FILE: hdl/rcs_checker.sv
// Port-level assertions for the RGB contrast stretch block, with its bind.
module rcs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          in_action,
    input logic          out_valid,
    input logic          out_ready,
    input rcs_pkg::pix_t red_out,
    input rcs_pkg::pix_t green_out,
    input rcs_pkg::pix_t blue_out
);
    import rcs_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // A stretch word occupies the block, so ready must drop.
    a_stretch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_action == ACT_STRETCH)) |=> !in_ready)
        else $error("ready stayed high after a stretch word");

    // A gather word finishes at once, so the block stays ready.
    a_gather_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_action == ACT_GATHER)) |=> in_ready)
        else $error("ready dropped after a gather word");

    // No output word can appear right after an input word is taken.
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(out_valid))
        else $error("output word appeared too early");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out)))
        else $error("stalled output word changed");

endmodule

bind rgb_contrast_stretch rcs_checker u_rcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .in_action (pix_in.action),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .red_out   (pix_out.red_out),
    .green_out (pix_out.green_out),
    .blue_out  (pix_out.blue_out)
);
